// ----- rtl/fau_pkg.sv -----
// Shared types and constants for the framed angle unwrap block.
// No dependencies; imported by fau_align, framed_angle_unwrap_core and the bench files.
`timescale 1ns / 1ps
`default_nettype none

package fau_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int BYTE_W      = 8;
    localparam int ANGLE_W     = 16;
    localparam int TURNS_W     = 16;
    localparam int UNWRAP_W    = 25;

    localparam logic [ANGLE_W-1:0] WRAP_HIGH = 16'd345;
    localparam logic [ANGLE_W-1:0] WRAP_LOW  = 16'd15;
    localparam logic signed [UNWRAP_W-1:0] DEG_PER_TURN = 25'sd360;

    localparam logic signed [TURNS_W-1:0] TURNS_MAX = 16'sh7fff;
    localparam logic signed [TURNS_W-1:0] TURNS_MIN = 16'sh8000;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd170;
    localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'd85;

    // configuration register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_STOP_MARKER  = 1'b1;

    typedef logic [BYTE_W-1:0] frame_byte_t;

    typedef struct packed {
        logic               found;
        logic [ANGLE_W-1:0] angle;
    } align_result_t;

endpackage

`default_nettype wire

// ----- rtl/fau_align.sv -----
// Frame alignment search: finds the lowest start position preceded by the
// stop marker and extracts the big-endian angle. Depends on fau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fau_align (
    input  wire fau_pkg::frame_byte_t   frame [fau_pkg::FRAME_BYTES],
    input  wire fau_pkg::frame_byte_t   start_marker,
    input  wire fau_pkg::frame_byte_t   stop_marker,
    output fau_pkg::align_result_t      result
);
    import fau_pkg::*;

    logic [FRAME_BYTES-1:0] hit;
    logic [ANGLE_W-1:0]     cand_angle [FRAME_BYTES];

    for (genvar p = 0; p < FRAME_BYTES; p++) begin : g_pos
        localparam int PrevPos = (p + FRAME_BYTES - 1) % FRAME_BYTES;
        localparam int HiPos   = (p + 1) % FRAME_BYTES;
        localparam int LoPos   = (p + 2) % FRAME_BYTES;

        assign hit[p] = (frame[p] == start_marker) && (frame[PrevPos] == stop_marker);
        assign cand_angle[p] = {frame[HiPos], frame[LoPos]};
    end

    // scan downward so the lowest matching position wins
    always_comb
    begin
        result.found = 1'b0;
        result.angle = '0;
        for (int p = FRAME_BYTES - 1; p >= 0; p--)
        begin
            if (hit[p])
            begin
                result.found = 1'b1;
                result.angle = cand_angle[p];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/framed_angle_unwrap_core.sv -----
// Framed angle unwrap core: input register, alignment and turn update,
// result register. Depends on fau_pkg and fau_align.
//
// Usage:
//   Input channel: in_valid / in_stall with byte0..byte7, one received frame
//   per transfer. Output channel: out_valid / out_stall with angle_raw,
//   turns, unwrapped_angle and frame_found, one result per frame.
//   A frame goes into the input register, then alignment search and the turn
//   update run combinationally into the result register, which raises
//   out_valid. One frame per cycle is sustained while the receiver does not
//   stall; the combinational previous-angle / turn-count update is what sets
//   that rate.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only when both are occupied.
//   APB port: start_marker at 0x0, stop_marker at 0x4, written while idle.
//   Reset: markers return to 170 and 85, previous angle and turns to zero,
//   both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module framed_angle_unwrap_core (
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  [7:0]                           byte0,
    input  wire  [7:0]                           byte1,
    input  wire  [7:0]                           byte2,
    input  wire  [7:0]                           byte3,
    input  wire  [7:0]                           byte4,
    input  wire  [7:0]                           byte5,
    input  wire  [7:0]                           byte6,
    input  wire  [7:0]                           byte7,

    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic        [fau_pkg::ANGLE_W-1:0]   angle_raw,
    output logic signed [fau_pkg::TURNS_W-1:0]   turns,
    output logic signed [fau_pkg::UNWRAP_W-1:0]  unwrapped_angle,
    output logic                                 frame_found,

    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [fau_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [fau_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [fau_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import fau_pkg::*;

    // configuration
    frame_byte_t start_marker_reg;
    frame_byte_t stop_marker_reg;
    logic        reg_sel;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            stop_marker_reg  <= STOP_MARKER_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_START_MARKER: start_marker_reg <= pwdata[BYTE_W-1:0];
                REG_STOP_MARKER:  stop_marker_reg  <= pwdata[BYTE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START_MARKER: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, start_marker_reg};
            REG_STOP_MARKER:  prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, stop_marker_reg};
            default:          prdata = '0;
        endcase
    end

    // handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic stage_advance;
    logic in_take;

    assign stage_advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = in_valid_reg && !stage_advance;
    assign in_take       = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (stage_advance)
                in_valid_reg <= 1'b0;

            if (stage_advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // input register
    frame_byte_t frame_reg [FRAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            frame_reg[0] <= byte0;
            frame_reg[1] <= byte1;
            frame_reg[2] <= byte2;
            frame_reg[3] <= byte3;
            frame_reg[4] <= byte4;
            frame_reg[5] <= byte5;
            frame_reg[6] <= byte6;
            frame_reg[7] <= byte7;
        end
    end

    align_result_t align;

    fau_align u_align (
        .frame        (frame_reg),
        .start_marker (start_marker_reg),
        .stop_marker  (stop_marker_reg),
        .result       (align)
    );

    // turn tracking
    logic        [ANGLE_W-1:0]  prev_angle_reg;
    logic signed [TURNS_W-1:0]  turn_count_reg;
    logic        [ANGLE_W-1:0]  angle_next;
    logic signed [TURNS_W-1:0]  turn_count_next;
    logic signed [UNWRAP_W-1:0] unwrapped_next;

    always_comb
    begin
        angle_next      = align.found ? align.angle : prev_angle_reg;
        turn_count_next = turn_count_reg;
        if ((prev_angle_reg > WRAP_HIGH) && (angle_next < WRAP_LOW))
        begin
            if (turn_count_reg != TURNS_MAX)
                turn_count_next = turn_count_reg + 16'sd1;
        end
        else if ((prev_angle_reg < WRAP_LOW) && (angle_next > WRAP_HIGH))
        begin
            if (turn_count_reg != TURNS_MIN)
                turn_count_next = turn_count_reg - 16'sd1;
        end
        unwrapped_next = UNWRAP_W'(UNWRAP_W'(turn_count_next) * DEG_PER_TURN)
                       + $signed({{(UNWRAP_W-ANGLE_W){1'b0}}, angle_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            turn_count_reg <= '0;
        end
        else if (stage_advance)
        begin
            prev_angle_reg <= angle_next;
            turn_count_reg <= turn_count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (stage_advance)
        begin
            angle_raw       <= angle_next;
            turns           <= turn_count_next;
            unwrapped_angle <= unwrapped_next;
            frame_found     <= align.found;
        end
    end

endmodule

`default_nettype wire

// ----- bench/fau_unwrap_monitor.sv -----
`timescale 1ns / 1ps
// Scoreboard for framed_angle_unwrap_core: mirrors marker register writes,
// predicts angle, turns and unwrapped angle per frame, checks every result.
// Depends on fau_pkg.

module fau_unwrap_monitor (
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  in_valid,
    input  wire                                  in_stall,
    input  wire  [7:0]                           byte0,
    input  wire  [7:0]                           byte1,
    input  wire  [7:0]                           byte2,
    input  wire  [7:0]                           byte3,
    input  wire  [7:0]                           byte4,
    input  wire  [7:0]                           byte5,
    input  wire  [7:0]                           byte6,
    input  wire  [7:0]                           byte7,

    input  wire                                  out_valid,
    input  wire                                  out_stall,
    input  wire         [fau_pkg::ANGLE_W-1:0]   angle_raw,
    input  wire  signed [fau_pkg::TURNS_W-1:0]   turns,
    input  wire  signed [fau_pkg::UNWRAP_W-1:0]  unwrapped_angle,
    input  wire                                  frame_found,

    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire                                  pready,
    input  wire  [fau_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [fau_pkg::APB_DATA_W-1:0]       pwdata,

    output int                                   fail_count,
    output int                                   expected_left
);

    import fau_pkg::*;

    typedef struct packed {
        logic        [ANGLE_W-1:0]  angle;
        logic signed [TURNS_W-1:0]  turns;
        logic signed [UNWRAP_W-1:0] unwrapped;
        logic                       found;
    } angle_sample_t;

    frame_byte_t        start_mark;
    frame_byte_t        stop_mark;
    logic [ANGLE_W-1:0] prior_angle;
    int                 turn_total;
    angle_sample_t      pending_angles [$];

    // Align one frame, advance the turn count and return the expected result.
    function automatic angle_sample_t unwrap_frame(input logic [FRAME_BYTES*BYTE_W-1:0] frame);
        frame_byte_t        b [FRAME_BYTES];
        logic [ANGLE_W-1:0] angle;
        logic               hit;
        logic signed [31:0] flat;
        int                 p;
        int                 prv;
        angle_sample_t      r;
        for (p = 0; p < FRAME_BYTES; p++)
            b[p] = frame[BYTE_W*p +: BYTE_W];
        angle = prior_angle;
        hit   = 1'b0;
        // lowest matching position wins
        for (p = 0; p < FRAME_BYTES; p++)
        begin
            prv = (p + FRAME_BYTES - 1) % FRAME_BYTES;
            if (!hit && b[p] == start_mark && b[prv] == stop_mark)
            begin
                angle = {b[(p + 1) % FRAME_BYTES], b[(p + 2) % FRAME_BYTES]};
                hit   = 1'b1;
            end
        end
        if (prior_angle > WRAP_HIGH && angle < WRAP_LOW)
        begin
            if (turn_total < int'(TURNS_MAX))
                turn_total = turn_total + 1;
        end
        else if (prior_angle < WRAP_LOW && angle > WRAP_HIGH)
        begin
            if (turn_total > int'(TURNS_MIN))
                turn_total = turn_total - 1;
        end
        prior_angle = angle;
        flat        = 360 * turn_total + int'(angle);
        r.angle     = angle;
        r.turns     = turn_total[TURNS_W-1:0];
        r.unwrapped = flat[UNWRAP_W-1:0];
        r.found     = hit;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        angle_sample_t got;
        angle_sample_t want;
        int            errs;
        errs = 0;
        if (!rst_n)
        begin
            start_mark  = START_MARKER_RST;
            stop_mark   = STOP_MARKER_RST;
            prior_angle = '0;
            turn_total  = 0;
            pending_angles.delete();
            fail_count    <= 0;
            expected_left <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[APB_ADDR_W-1:2] == REG_START_MARKER)
                    start_mark = pwdata[BYTE_W-1:0];
                else if (paddr[APB_ADDR_W-1:2] == REG_STOP_MARKER)
                    stop_mark = pwdata[BYTE_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                got = '{angle_raw, turns, unwrapped_angle, frame_found};
                if (pending_angles.size() == 0)
                begin
                    $error("result transfer with no frame outstanding: angle_raw %0d", angle_raw);
                    errs++;
                end
                else
                begin
                    want = pending_angles.pop_front();
                    if (got.angle !== want.angle)
                    begin
                        $error("angle_raw: expected %0d, got %0d", want.angle, got.angle);
                        errs++;
                    end
                    if (got.turns !== want.turns)
                    begin
                        $error("turns: expected %0d, got %0d", want.turns, got.turns);
                        errs++;
                    end
                    if (got.unwrapped !== want.unwrapped)
                    begin
                        $error("unwrapped_angle: expected %0d, got %0d",
                               want.unwrapped, got.unwrapped);
                        errs++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("frame_found: expected %0d, got %0d", want.found, got.found);
                        errs++;
                    end
                end
            end

            if (in_valid && !in_stall)
                pending_angles.push_back(unwrap_frame({byte7, byte6, byte5, byte4,
                                                       byte3, byte2, byte1, byte0}));

            fail_count    <= fail_count + errs;
            expected_left <= pending_angles.size();
        end
    end

endmodule

// ----- bench/framed_angle_unwrap_core_test.sv -----
`timescale 1ns / 1ps
// Top of the framed_angle_unwrap_core bench: clock, reset, frame and marker
// stimulus with random idling, watchdog and verdict.
// Depends on fau_pkg, framed_angle_unwrap_core and fau_unwrap_monitor.

module framed_angle_unwrap_core_test;

    import fau_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 110;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    frame_byte_t                  byte0, byte1, byte2, byte3;
    frame_byte_t                  byte4, byte5, byte6, byte7;
    logic                         out_valid;
    logic                         out_stall;
    logic        [ANGLE_W-1:0]    angle_raw;
    logic signed [TURNS_W-1:0]    turns;
    logic signed [UNWRAP_W-1:0]   unwrapped_angle;
    logic                         frame_found;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic        [APB_ADDR_W-1:0] paddr;
    logic        [APB_DATA_W-1:0] pwdata;
    logic        [APB_DATA_W-1:0] prdata;
    logic                         pready;

    int          fail_count;
    int          expected_left;
    int          quiet_cycles = 0;
    int          stall_left;
    int          walk_angle;
    bit          idle_on;
    frame_byte_t cur_start;
    frame_byte_t cur_stop;

    framed_angle_unwrap_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
        .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
        .out_valid(out_valid), .out_stall(out_stall),
        .angle_raw(angle_raw), .turns(turns),
        .unwrapped_angle(unwrapped_angle), .frame_found(frame_found),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fau_unwrap_monitor checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
        .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
        .out_valid(out_valid), .out_stall(out_stall),
        .angle_raw(angle_raw), .turns(turns),
        .unwrapped_angle(unwrapped_angle), .frame_found(frame_found),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .expected_left(expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: stall in random bursts while idling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Build a well-formed frame for the current markers, rotated by rot.
    function automatic logic [63:0] aligned_frame(input logic [15:0] angle, input int rot);
        frame_byte_t a [FRAME_BYTES];
        logic [63:0] f;
        int          k;
        a[0] = cur_start;
        a[1] = angle[15:8];
        a[2] = angle[7:0];
        // keep fillers off the start marker so no filler position starts a second alignment
        for (k = 3; k < FRAME_BYTES - 1; k++)
        begin
            a[k] = frame_byte_t'($urandom);
            if (a[k] == cur_start)
                a[k] = cur_start + 8'd1;
        end
        a[FRAME_BYTES-1] = cur_stop;
        for (k = 0; k < FRAME_BYTES; k++)
            f[8*((k + rot) % FRAME_BYTES) +: 8] = a[k];
        return f;
    endfunction

    // Mostly a random walk that crosses the wrap point, plus edge and wild values.
    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                walk_angle = (walk_angle + 390 - int'($urandom_range(0, 60))) % 360;
                a = walk_angle[15:0];
            end
            6:       a = 16'($urandom_range(0, 14));
            7:       a = 16'($urandom_range(346, 359));
            8:       a = 16'($urandom_range(0, 359));
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    task automatic push_frame(input logic [63:0] frame);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0} <= frame;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(input logic reg_index, input frame_byte_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then load both markers.
    task automatic set_markers(input frame_byte_t start_value, input frame_byte_t stop_value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (2) @(posedge clk);
        write_reg(REG_START_MARKER, start_value);
        write_reg(REG_STOP_MARKER, stop_value);
        cur_start = start_value;
        cur_stop  = stop_value;
    endtask

    initial
    begin
        frame_byte_t start_set [5];
        frame_byte_t stop_set  [5];
        logic [63:0] frame;
        int          ph;
        int          n;
        int          kind;

        start_set = '{8'h00, 8'hFF, 8'h7E, 8'h00, 8'h3C};
        stop_set  = '{8'hFF, 8'h00, 8'h7E, 8'h00, 8'hC3};

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0} <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        walk_angle   = 180;
        idle_on      = 1'b1;
        cur_start    = START_MARKER_RST;
        cur_stop     = STOP_MARKER_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset markers, no-frame cases, wrap boundaries, extremes
        push_frame('0);
        push_frame('1);
        push_frame(aligned_frame(16'd0, 0));
        push_frame(aligned_frame(16'd359, 3));
        push_frame(aligned_frame(16'd5, 7));
        push_frame(aligned_frame(16'hFFFF, 6));
        push_frame(aligned_frame(16'd0, 1));
        push_frame({8{8'hAA}});
        push_frame(aligned_frame(16'd345, 2));
        push_frame(aligned_frame(16'd14, 5));
        push_frame(aligned_frame(16'd346, 4));
        push_frame(aligned_frame(16'd15, 0));
        push_frame(aligned_frame(16'd14, 6));
        push_frame(aligned_frame(16'd346, 7));
        // two alignments, at positions 2 and 6: the first one counts
        push_frame({8'h01, 8'hAA, 8'h55, 8'h10, 8'h00, 8'hAA, 8'h55, 8'h20});
        // start marker present but preceded by the wrong byte
        push_frame({8'h00, 8'h54, 8'hAA, 8'h01, 8'h00, 8'hAA, 8'h56, 8'h20});
        push_frame(aligned_frame(16'h8000, 1));
        push_frame(aligned_frame(16'h7FFF, 2));

        // random phases over several marker settings, extremes included
        for (ph = 0; ph < 5; ph++)
        begin
            if (ph == 3)
                set_markers(frame_byte_t'($urandom), frame_byte_t'($urandom));
            else
                set_markers(start_set[ph], stop_set[ph]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                idle_on = (n < 70);
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    push_frame(aligned_frame(pick_angle(), $urandom_range(0, 7)));
                else if (kind < 17)
                    push_frame({$urandom, $urandom});
                else
                begin
                    // break one byte of a good frame
                    frame = aligned_frame(pick_angle(), $urandom_range(0, 7));
                    frame[8*$urandom_range(0, 7) +: 8] ^= 8'(1 << $urandom_range(0, 7));
                    push_frame(frame);
                end
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
